FILE: src/cmm_pkg.sv
package cmm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int Q_BITS    = 32;
	localparam int MAG_W     = 64;
	localparam int PROD_W    = 64;
	localparam int SUM_W     = 66;
	localparam int CFG_IDX_W = 4;
	localparam int DIV_LAT   = Q_BITS + 2;
	localparam int LATENCY   = 9 + 2 * DIV_LAT;

	localparam logic signed [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] MAX32   = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] MIN32   = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] point_re;
		logic signed [DATA_W-1:0] point_im;
	} point_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] image_re;
		logic signed [DATA_W-1:0] image_im;
		logic signed [DATA_W-1:0] slope_re;
		logic signed [DATA_W-1:0] slope_im;
		logic [1:0]               status;
	} result_t;

	function automatic logic signed [SUM_W-1:0] sx(input logic signed [PROD_W-1:0] v);
		return SUM_W'(v);
	endfunction

	function automatic logic ovf32(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){v[DATA_W-1]}};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (ovf32(v)) begin
			r = v[SUM_W-1] ? MIN32 : MAX32;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] a;
		a = v[SUM_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

endpackage

FILE: src/cmm_div.sv
module cmm_div (
	input  logic                                     clk,
	input  logic [cmm_pkg::MAG_W-1:0]                mag,
	input  logic                                     neg,
	input  logic [cmm_pkg::MAG_W-1:0]                den,
	output logic signed [cmm_pkg::DATA_W-1:0]        quo,
	output logic                                     sat
);
	import cmm_pkg::*;

	localparam int SH = Q_BITS - FRAC_BITS;

	logic [MAG_W:0]       rem_q  [0:Q_BITS];
	logic [Q_BITS-1:0]    low_q  [0:Q_BITS];
	logic [Q_BITS-1:0]    part_q [0:Q_BITS];
	logic [MAG_W-1:0]     den_q  [0:Q_BITS];
	logic [Q_BITS:0]      neg_q;
	logic [Q_BITS:0]      big_q;

	logic [MAG_W:0]       rem_c  [0:Q_BITS-1];
	logic [Q_BITS-1:0]    part_c [0:Q_BITS-1];

	logic [MAG_W+SH-1:0]  mag_x;
	logic [MAG_W+SH-1:0]  den_x;

	logic signed [DATA_W-1:0] quo_q;
	logic                     sat_q;
	logic [Q_BITS-1:0]        q_fin;
	logic signed [Q_BITS:0]   q_neg;

	assign mag_x = {{SH{1'b0}}, mag};
	assign den_x = {den, {SH{1'b0}}};

	always_comb begin
		logic [MAG_W:0] t;
		logic           ge;
		for (int k = 0; k < Q_BITS; k++) begin
			t         = {rem_q[k][MAG_W-1:0], low_q[k][Q_BITS-1]};
			ge        = t >= {1'b0, den_q[k]};
			rem_c[k]  = ge ? t - {1'b0, den_q[k]} : t;
			part_c[k] = {part_q[k][Q_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0]  <= (MAG_W+1)'(mag >> SH);
		low_q[0]  <= Q_BITS'(mag << FRAC_BITS);
		part_q[0] <= '0;
		den_q[0]  <= den;
		neg_q[0]  <= neg;
		big_q[0]  <= mag_x >= den_x;
		for (int k = 1; k <= Q_BITS; k++) begin
			rem_q[k]  <= rem_c[k-1];
			low_q[k]  <= low_q[k-1] << 1;
			part_q[k] <= part_c[k-1];
			den_q[k]  <= den_q[k-1];
			neg_q[k]  <= neg_q[k-1];
			big_q[k]  <= big_q[k-1];
		end
	end

	assign q_fin = part_q[Q_BITS];
	assign q_neg = -$signed({1'b0, q_fin});

	always_ff @(posedge clk) begin
		if (neg_q[Q_BITS]) begin
			if (big_q[Q_BITS] || q_fin > {1'b1, {(Q_BITS-1){1'b0}}}) begin
				quo_q <= MIN32;
				sat_q <= 1'b1;
			end else begin
				quo_q <= q_neg[DATA_W-1:0];
				sat_q <= 1'b0;
			end
		end else begin
			if (big_q[Q_BITS] || q_fin[Q_BITS-1]) begin
				quo_q <= MAX32;
				sat_q <= 1'b1;
			end else begin
				quo_q <= q_fin;
				sat_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign sat = sat_q;

endmodule

FILE: src/complex_moebius_map_and_derivative.sv
// Mobius map f(p) = (a p + b) / (c p + d) and its derivative, in signed Q16.16.
// A point is taken on every cycle (busy never rises) and its word appears with
// done after the stage registers and both divider banks. Two banks of
// bit-per-stage dividers run in series (34 stages each), the derivative quotient
// waiting on the first. The receiver cannot stall; done marks each word for one
// cycle. Coefficients are written over the cfg channel (always ready) and must
// only change while no point is in flight. A zero denominator gives zero outputs
// with status 1; any saturation on the way gives status 2.
module complex_moebius_map_and_derivative (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  cmm_pkg::point_t                 point,
	output logic                            done,
	output cmm_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cmm_pkg::DATA_W-1:0]      cfg_data
);
	import cmm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_A_RE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_A_IM = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_B_RE = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_B_IM = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_C_RE = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_C_IM = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_D_RE = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_D_IM = CFG_IDX_W'(7);

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic             zero;
		logic             sat;
		fix_t             nr;
		fix_t             ni;
		logic [MAG_W-1:0] den;
	} wside_t;

	typedef struct packed {
		logic zero;
		logic sat;
		fix_t fr;
		fix_t fi;
	} sside_t;

	fix_t coef_a_re_q, coef_a_im_q, coef_b_re_q, coef_b_im_q;
	fix_t coef_c_re_q, coef_c_im_q, coef_d_re_q, coef_d_im_q;

	// stage 1
	logic  valid_s1;
	prod_t ar_pr_s1, ai_pi_s1, ar_pi_s1, ai_pr_s1;
	prod_t cr_pr_s1, ci_pi_s1, cr_pi_s1, ci_pr_s1;
	// stage 2
	logic  valid_s2, sat_s2;
	fix_t  ur_s2, ui_s2, nr_s2, ni_s2;
	logic signed [SUM_W-1:0] ur_c, ui_c, nr_c, ni_c;
	// stage 3
	logic  valid_s3, sat_s3, zero_s3;
	fix_t  nr_s3, ni_s3;
	prod_t ur_nr_s3, ui_ni_s3, ui_nr_s3, ur_ni_s3, nr_nr_s3, ni_ni_s3;
	prod_t ar_nr_s3, ai_ni_s3, ur_cr_s3, ui_ci_s3;
	prod_t ar_ni_s3, ai_nr_s3, ur_ci_s3, ui_cr_s3;
	// stage 4
	logic  valid_s4, sat_s4, zero_s4;
	fix_t  nr_s4, ni_s4, mr_s4, mi_s4;
	logic [MAG_W-1:0] fre_mag_s4, fim_mag_s4, den_s4;
	logic  fre_neg_s4, fim_neg_s4;
	logic signed [SUM_W-1:0] fre_c, fim_c, mr_c, mi_c;
	// stage 5
	logic  valid_s5, sat_s5, zero_s5;
	fix_t  nr_s5, ni_s5;
	logic [MAG_W-1:0] fre_mag_s5, fim_mag_s5, den_s5;
	logic  fre_neg_s5, fim_neg_s5;
	prod_t mr_nr_s5, mi_ni_s5, mi_nr_s5, mr_ni_s5;
	// stage 6
	logic  valid_s6, sat_s6, zero_s6;
	fix_t  nr_s6, ni_s6;
	logic [MAG_W-1:0] fre_mag_s6, fim_mag_s6, wre_mag_s6, wim_mag_s6, den_s6;
	logic  fre_neg_s6, fim_neg_s6, wre_neg_s6, wim_neg_s6;
	logic signed [SUM_W-1:0] wre_c, wim_c;
	// first divider bank
	fix_t  fr_d, fi_d, wr_d, wi_d;
	logic  fr_sat, fi_sat, wr_sat, wi_sat;
	logic [DIV_LAT-1:0] wvld_q;
	wside_t wside_q [0:DIV_LAT-1];
	wside_t wside_in, wside_out;
	// stage 7
	logic  valid_s7, sat_s7, zero_s7;
	fix_t  fr_s7, fi_s7;
	logic [MAG_W-1:0] den_s7;
	prod_t wr_nr_s7, wi_ni_s7, wi_nr_s7, wr_ni_s7;
	// stage 8
	logic  valid_s8, sat_s8, zero_s8;
	fix_t  fr_s8, fi_s8;
	logic [MAG_W-1:0] den_s8, sre_mag_s8, sim_mag_s8;
	logic  sre_neg_s8, sim_neg_s8;
	logic signed [SUM_W-1:0] sre_c, sim_c;
	// second divider bank
	fix_t  sr_d, si_d;
	logic  sr_sat, si_sat;
	logic [DIV_LAT-1:0] svld_q;
	sside_t sside_q [0:DIV_LAT-1];
	sside_t sside_out;
	// output
	logic    done_q;
	result_t result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_re_q <= FIX_ONE;
			coef_a_im_q <= '0;
			coef_b_re_q <= '0;
			coef_b_im_q <= '0;
			coef_c_re_q <= '0;
			coef_c_im_q <= '0;
			coef_d_re_q <= FIX_ONE;
			coef_d_im_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_A_RE: coef_a_re_q <= cfg_data;
				REG_A_IM: coef_a_im_q <= cfg_data;
				REG_B_RE: coef_b_re_q <= cfg_data;
				REG_B_IM: coef_b_im_q <= cfg_data;
				REG_C_RE: coef_c_re_q <= cfg_data;
				REG_C_IM: coef_c_im_q <= cfg_data;
				REG_D_RE: coef_d_re_q <= cfg_data;
				REG_D_IM: coef_d_im_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			wvld_q   <= '0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			svld_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			wvld_q   <= {wvld_q[DIV_LAT-2:0], valid_s6};
			valid_s7 <= wvld_q[DIV_LAT-1];
			valid_s8 <= valid_s7;
			svld_q   <= {svld_q[DIV_LAT-2:0], valid_s8};
			done_q   <= svld_q[DIV_LAT-1];
		end
	end

	// u and dn
	assign ur_c = ((sx(ar_pr_s1) - sx(ai_pi_s1)) >>> FRAC_BITS) + SUM_W'(coef_b_re_q);
	assign ui_c = ((sx(ar_pi_s1) + sx(ai_pr_s1)) >>> FRAC_BITS) + SUM_W'(coef_b_im_q);
	assign nr_c = ((sx(cr_pr_s1) - sx(ci_pi_s1)) >>> FRAC_BITS) + SUM_W'(coef_d_re_q);
	assign ni_c = ((sx(cr_pi_s1) + sx(ci_pr_s1)) >>> FRAC_BITS) + SUM_W'(coef_d_im_q);

	// image numerator and derivative numerator
	assign fre_c = sx(ur_nr_s3) + sx(ui_ni_s3);
	assign fim_c = sx(ui_nr_s3) - sx(ur_ni_s3);
	assign mr_c  = (sx(ar_nr_s3) - sx(ai_ni_s3) - sx(ur_cr_s3) + sx(ui_ci_s3)) >>> FRAC_BITS;
	assign mi_c  = (sx(ar_ni_s3) + sx(ai_nr_s3) - sx(ur_ci_s3) - sx(ui_cr_s3)) >>> FRAC_BITS;

	assign wre_c = sx(mr_nr_s5) + sx(mi_ni_s5);
	assign wim_c = sx(mi_nr_s5) - sx(mr_ni_s5);

	assign sre_c = sx(wr_nr_s7) + sx(wi_ni_s7);
	assign sim_c = sx(wi_nr_s7) - sx(wr_ni_s7);

	always_ff @(posedge clk) begin
		ar_pr_s1 <= coef_a_re_q * point.point_re;
		ai_pi_s1 <= coef_a_im_q * point.point_im;
		ar_pi_s1 <= coef_a_re_q * point.point_im;
		ai_pr_s1 <= coef_a_im_q * point.point_re;
		cr_pr_s1 <= coef_c_re_q * point.point_re;
		ci_pi_s1 <= coef_c_im_q * point.point_im;
		cr_pi_s1 <= coef_c_re_q * point.point_im;
		ci_pr_s1 <= coef_c_im_q * point.point_re;

		ur_s2  <= sat32(ur_c);
		ui_s2  <= sat32(ui_c);
		nr_s2  <= sat32(nr_c);
		ni_s2  <= sat32(ni_c);
		sat_s2 <= ovf32(ur_c) | ovf32(ui_c) | ovf32(nr_c) | ovf32(ni_c);

		sat_s3   <= sat_s2;
		zero_s3  <= (nr_s2 == '0) && (ni_s2 == '0);
		nr_s3    <= nr_s2;
		ni_s3    <= ni_s2;
		ur_nr_s3 <= ur_s2 * nr_s2;
		ui_ni_s3 <= ui_s2 * ni_s2;
		ui_nr_s3 <= ui_s2 * nr_s2;
		ur_ni_s3 <= ur_s2 * ni_s2;
		nr_nr_s3 <= nr_s2 * nr_s2;
		ni_ni_s3 <= ni_s2 * ni_s2;
		ar_nr_s3 <= coef_a_re_q * nr_s2;
		ai_ni_s3 <= coef_a_im_q * ni_s2;
		ur_cr_s3 <= ur_s2 * coef_c_re_q;
		ui_ci_s3 <= ui_s2 * coef_c_im_q;
		ar_ni_s3 <= coef_a_re_q * ni_s2;
		ai_nr_s3 <= coef_a_im_q * nr_s2;
		ur_ci_s3 <= ur_s2 * coef_c_im_q;
		ui_cr_s3 <= ui_s2 * coef_c_re_q;

		sat_s4     <= sat_s3 | ovf32(mr_c) | ovf32(mi_c);
		zero_s4    <= zero_s3;
		nr_s4      <= nr_s3;
		ni_s4      <= ni_s3;
		mr_s4      <= sat32(mr_c);
		mi_s4      <= sat32(mi_c);
		fre_mag_s4 <= mag_of(fre_c);
		fim_mag_s4 <= mag_of(fim_c);
		fre_neg_s4 <= fre_c[SUM_W-1];
		fim_neg_s4 <= fim_c[SUM_W-1];
		den_s4     <= $unsigned(nr_nr_s3) + $unsigned(ni_ni_s3);

		sat_s5     <= sat_s4;
		zero_s5    <= zero_s4;
		nr_s5      <= nr_s4;
		ni_s5      <= ni_s4;
		fre_mag_s5 <= fre_mag_s4;
		fim_mag_s5 <= fim_mag_s4;
		fre_neg_s5 <= fre_neg_s4;
		fim_neg_s5 <= fim_neg_s4;
		den_s5     <= den_s4;
		mr_nr_s5   <= mr_s4 * nr_s4;
		mi_ni_s5   <= mi_s4 * ni_s4;
		mi_nr_s5   <= mi_s4 * nr_s4;
		mr_ni_s5   <= mr_s4 * ni_s4;

		sat_s6     <= sat_s5;
		zero_s6    <= zero_s5;
		nr_s6      <= nr_s5;
		ni_s6      <= ni_s5;
		fre_mag_s6 <= fre_mag_s5;
		fim_mag_s6 <= fim_mag_s5;
		fre_neg_s6 <= fre_neg_s5;
		fim_neg_s6 <= fim_neg_s5;
		den_s6     <= den_s5;
		wre_mag_s6 <= mag_of(wre_c);
		wim_mag_s6 <= mag_of(wim_c);
		wre_neg_s6 <= wre_c[SUM_W-1];
		wim_neg_s6 <= wim_c[SUM_W-1];
	end

	cmm_div u_div_fr (.clk, .mag(fre_mag_s6), .neg(fre_neg_s6), .den(den_s6),
		.quo(fr_d), .sat(fr_sat));
	cmm_div u_div_fi (.clk, .mag(fim_mag_s6), .neg(fim_neg_s6), .den(den_s6),
		.quo(fi_d), .sat(fi_sat));
	cmm_div u_div_wr (.clk, .mag(wre_mag_s6), .neg(wre_neg_s6), .den(den_s6),
		.quo(wr_d), .sat(wr_sat));
	cmm_div u_div_wi (.clk, .mag(wim_mag_s6), .neg(wim_neg_s6), .den(den_s6),
		.quo(wi_d), .sat(wi_sat));

	assign wside_in  = '{zero: zero_s6, sat: sat_s6, nr: nr_s6, ni: ni_s6, den: den_s6};
	assign wside_out = wside_q[DIV_LAT-1];

	always_ff @(posedge clk) begin
		wside_q[0] <= wside_in;
		for (int k = 1; k < DIV_LAT; k++) begin
			wside_q[k] <= wside_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		sat_s7   <= wside_out.sat | fr_sat | fi_sat | wr_sat | wi_sat;
		zero_s7  <= wside_out.zero;
		fr_s7    <= fr_d;
		fi_s7    <= fi_d;
		den_s7   <= wside_out.den;
		wr_nr_s7 <= wr_d * wside_out.nr;
		wi_ni_s7 <= wi_d * wside_out.ni;
		wi_nr_s7 <= wi_d * wside_out.nr;
		wr_ni_s7 <= wr_d * wside_out.ni;

		sat_s8     <= sat_s7;
		zero_s8    <= zero_s7;
		fr_s8      <= fr_s7;
		fi_s8      <= fi_s7;
		den_s8     <= den_s7;
		sre_mag_s8 <= mag_of(sre_c);
		sim_mag_s8 <= mag_of(sim_c);
		sre_neg_s8 <= sre_c[SUM_W-1];
		sim_neg_s8 <= sim_c[SUM_W-1];
	end

	cmm_div u_div_sr (.clk, .mag(sre_mag_s8), .neg(sre_neg_s8), .den(den_s8),
		.quo(sr_d), .sat(sr_sat));
	cmm_div u_div_si (.clk, .mag(sim_mag_s8), .neg(sim_neg_s8), .den(den_s8),
		.quo(si_d), .sat(si_sat));

	assign sside_out = sside_q[DIV_LAT-1];

	always_ff @(posedge clk) begin
		sside_q[0] <= '{zero: zero_s8, sat: sat_s8, fr: fr_s8, fi: fi_s8};
		for (int k = 1; k < DIV_LAT; k++) begin
			sside_q[k] <= sside_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (sside_out.zero) begin
			result_q.image_re <= '0;
			result_q.image_im <= '0;
			result_q.slope_re <= '0;
			result_q.slope_im <= '0;
			result_q.status   <= ST_ZERO;
		end else begin
			result_q.image_re <= sside_out.fr;
			result_q.image_im <= sside_out.fi;
			result_q.slope_re <= sr_d;
			result_q.slope_im <= si_d;
			result_q.status   <= (sside_out.sat | sr_sat | si_sat) ? ST_SAT : ST_OK;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: src/cmm_checker.sv
module cmm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input cmm_pkg::point_t                 point,
	input logic                            done,
	input cmm_pkg::result_t                result,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [cmm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [cmm_pkg::DATA_W-1:0]      cfg_data
);
	import cmm_pkg::*;

	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted point gave no word");

	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("word without an accepted point");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_ZERO |-> result.image_re == '0 &&
			result.image_im == '0 && result.slope_re == '0 && result.slope_im == '0)
		else $error("zero denominator word carries data");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status == ST_OK || result.status == ST_ZERO ||
			result.status == ST_SAT)
		else $error("bad status code");

endmodule

bind complex_moebius_map_and_derivative cmm_checker u_cmm_checker (.*);

FILE: verif/complex_moebius_map_and_derivative_tb.sv
`timescale 1ns / 100ps

module complex_moebius_map_and_derivative_tb;
	import cmm_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [DATA_W-1:0] fix_t;

	typedef enum logic [1:0] {OP_POINT, OP_COEF, OP_SETTLE} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		point_t            pt;
		logic [CFG_IDX_W-1:0] idx;
		logic [DATA_W-1:0] data;
		int                gap_pct;
	} op_t;

	localparam int NUM_COEF = 8;
	localparam int IDX_A_RE = 0, IDX_A_IM = 1, IDX_B_RE = 2, IDX_B_IM = 3;
	localparam int IDX_C_RE = 4, IDX_C_IM = 5, IDX_D_RE = 6, IDX_D_IM = 7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	op_t pending_ops[$];
	result_t expected_words[$];
	fix_t coef[NUM_COEF];
	int errors = 0;
	bit all_sent = 1'b0;
	int settle_cnt = 0;

	complex_moebius_map_and_derivative i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .point(point),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic fix_t clamp32(input wide_t v, inout logic flag);
		fix_t r;
		if (v > wide_t'(MAX32)) begin
			flag = 1'b1;
			r = MAX32;
		end else if (v < wide_t'(MIN32)) begin
			flag = 1'b1;
			r = MIN32;
		end else begin
			r = fix_t'(v);
		end
		return r;
	endfunction

	// truncated (num << FRAC_BITS) / den, clamped
	function automatic fix_t scaled_quot(input wide_t num, input wide_t den, inout logic flag);
		wide_t m, q;
		fix_t r;
		m = num < 0 ? -num : num;
		q = (m <<< FRAC_BITS) / den;
		if (num < 0) begin
			if (q > wide_t'(64'h8000_0000)) begin
				flag = 1'b1;
				r = MIN32;
			end else begin
				r = fix_t'(-q);
			end
		end else if (q > wide_t'(MAX32)) begin
			flag = 1'b1;
			r = MAX32;
		end else begin
			r = fix_t'(q);
		end
		return r;
	endfunction

	function automatic void cplx_div(input wide_t xr, xi, yr, yi, output fix_t qr, qi,
			inout logic flag);
		wide_t den;
		den = yr * yr + yi * yi;
		qr = scaled_quot(xr * yr + xi * yi, den, flag);
		qi = scaled_quot(xi * yr - xr * yi, den, flag);
	endfunction

	function automatic result_t mobius_of(input point_t p);
		wide_t pr, pi, ar, ai, br, bi, cr, ci, dr, di;
		wide_t ur, ui, nr, ni, mr, mi;
		fix_t wr, wi, fr, fi, sr, si;
		logic sat;
		result_t r;
		pr = wide_t'(p.point_re); pi = wide_t'(p.point_im);
		ar = wide_t'(coef[IDX_A_RE]); ai = wide_t'(coef[IDX_A_IM]);
		br = wide_t'(coef[IDX_B_RE]); bi = wide_t'(coef[IDX_B_IM]);
		cr = wide_t'(coef[IDX_C_RE]); ci = wide_t'(coef[IDX_C_IM]);
		dr = wide_t'(coef[IDX_D_RE]); di = wide_t'(coef[IDX_D_IM]);
		sat = 1'b0;
		ur = wide_t'(clamp32(((ar * pr - ai * pi) >>> FRAC_BITS) + br, sat));
		ui = wide_t'(clamp32(((ar * pi + ai * pr) >>> FRAC_BITS) + bi, sat));
		nr = wide_t'(clamp32(((cr * pr - ci * pi) >>> FRAC_BITS) + dr, sat));
		ni = wide_t'(clamp32(((cr * pi + ci * pr) >>> FRAC_BITS) + di, sat));
		r = '0;
		if (nr == 0 && ni == 0) begin
			r.status = ST_ZERO;
		end else begin
			cplx_div(ur, ui, nr, ni, fr, fi, sat);
			mr = wide_t'(clamp32((ar * nr - ai * ni - ur * cr + ui * ci) >>> FRAC_BITS, sat));
			mi = wide_t'(clamp32((ar * ni + ai * nr - ur * ci - ui * cr) >>> FRAC_BITS, sat));
			cplx_div(mr, mi, nr, ni, wr, wi, sat);
			cplx_div(wide_t'(wr), wide_t'(wi), nr, ni, sr, si, sat);
			r.image_re = fr;
			r.image_im = fi;
			r.slope_re = sr;
			r.slope_im = si;
			r.status = sat ? ST_SAT : ST_OK;
		end
		return r;
	endfunction

	// driver: handshakes first, then the next word
	always @(posedge clk) begin
		logic acc_pt, acc_cfg, hold;
		logic nx_start, nx_valid;
		op_t head;
		if (arst_n) begin
			acc_pt = start && !busy;
			acc_cfg = cfg_valid && cfg_ready;
			if (acc_pt) expected_words.push_back(mobius_of(point));
			if (acc_cfg && cfg_index < NUM_COEF) coef[cfg_index] = cfg_data;
			hold = (start && !acc_pt) || (cfg_valid && !acc_cfg);
			nx_start = hold ? start : 1'b0;
			nx_valid = hold ? cfg_valid : 1'b0;
			if (!hold) begin
				if (pending_ops.size() == 0) begin
					all_sent = 1'b1;
				end else begin
					head = pending_ops[0];
					case (head.kind)
						OP_POINT: begin
							if ($urandom_range(99) >= head.gap_pct) begin
								nx_start = 1'b1;
								point <= head.pt;
								void'(pending_ops.pop_front());
							end
						end
						OP_COEF: begin
							nx_valid = 1'b1;
							cfg_index <= head.idx;
							cfg_data <= head.data;
							void'(pending_ops.pop_front());
						end
						default: begin
							if (expected_words.size() != 0 || acc_pt) begin
								settle_cnt = 0;
							end else if (settle_cnt >= LATENCY + 4) begin
								settle_cnt = 0;
								void'(pending_ops.pop_front());
							end else begin
								settle_cnt++;
							end
						end
					endcase
				end
			end
			start <= nx_start;
			cfg_valid <= nx_valid;
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (result.image_re !== want.image_re || result.image_im !== want.image_im ||
						result.slope_re !== want.slope_re ||
						result.slope_im !== want.slope_im || result.status !== want.status) begin
					$display("%0t: mismatch expected %h %h %h %h st %0d, got %h %h %h %h st %0d",
						$time, want.image_re, want.image_im, want.slope_re, want.slope_im,
						want.status, result.image_re, result.image_im, result.slope_re,
						result.slope_im, result.status);
					errors++;
				end
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_fix();
		logic [DATA_W-1:0] v;
		case ($urandom_range(9))
			0: v = $urandom;
			1: v = $urandom_range(2) == 0 ? MAX32 : ($urandom_range(1) ? MIN32 : '0);
			2, 3: v = DATA_W'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
			default: v = DATA_W'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
		endcase
		return v;
	endfunction

	task automatic add_point(input logic [DATA_W-1:0] re, im, input int gap);
		op_t o;
		o.kind = OP_POINT;
		o.pt.point_re = re;
		o.pt.point_im = im;
		o.idx = '0;
		o.data = '0;
		o.gap_pct = gap;
		pending_ops.push_back(o);
	endtask

	task automatic add_coef(input int idx, input logic [DATA_W-1:0] val);
		op_t o;
		o.kind = OP_COEF;
		o.pt = '0;
		o.idx = CFG_IDX_W'(idx);
		o.data = val;
		o.gap_pct = 0;
		pending_ops.push_back(o);
	endtask

	task automatic add_settle();
		op_t o;
		o.kind = OP_SETTLE;
		o.pt = '0;
		o.idx = '0;
		o.data = '0;
		o.gap_pct = 0;
		pending_ops.push_back(o);
	endtask

	initial begin
		int gap;
		for (int i = 0; i < NUM_COEF; i++) coef[i] = '0;
		coef[IDX_A_RE] = FIX_ONE;
		coef[IDX_D_RE] = FIX_ONE;

		// identity map after reset, field extremes
		add_point('0, '0, 18);
		add_point(MAX32, MIN32, 18);
		add_point(MIN32, MAX32, 18);
		add_point(32'hFFFF_FFFF, 32'hAAAA_5555, 18);
		add_point(FIX_ONE, -FIX_ONE, 18);
		add_settle();
		// zero denominator everywhere
		for (int i = 0; i < NUM_COEF; i++) add_coef(i, '0);
		add_point(FIX_ONE, FIX_ONE, 18);
		add_point(MIN32, MIN32, 18);
		add_settle();
		// extreme coefficients, saturation on every path
		for (int i = 0; i < NUM_COEF; i++) add_coef(i, i[0] ? MIN32 : MAX32);
		add_point(MAX32, MAX32, 18);
		add_point(MIN32, '0, 18);
		add_point(32'h0000_0001, 32'hFFFF_FFFF, 18);
		add_settle();
		// tiny denominator: quotient overflow; pole at p = 1
		add_coef(IDX_A_RE, FIX_ONE);
		add_coef(IDX_A_IM, '0);
		add_coef(IDX_B_RE, '0);
		add_coef(IDX_B_IM, '0);
		add_coef(IDX_C_RE, FIX_ONE);
		add_coef(IDX_C_IM, '0);
		add_coef(IDX_D_RE, -FIX_ONE);
		add_coef(IDX_D_IM, '0);
		add_coef(8, 32'h1234_5678);
		add_coef(15, MAX32);
		add_point(FIX_ONE, '0, 18);
		add_point(FIX_ONE + 1, '0, 18);
		add_point(FIX_ONE, 32'h0000_0001, 18);
		add_point(32'h0002_0000, 32'h0001_0000, 18);
		add_point('0, '0, 18);
		add_settle();

		for (int ph = 0; ph < 6; ph++) begin
			gap = ph < 2 ? 18 : (ph < 4 ? 53 : 0);
			for (int i = 0; i < NUM_COEF; i++) add_coef(i, pick_fix());
			if ($urandom_range(3) == 0) add_coef($urandom_range(15, 8), $urandom);
			for (int n = 0; n < 122; n++) begin
				if ($urandom_range(40) == 0) add_point('0, '0, gap);
				else add_point(pick_fix(), pick_fix(), gap);
			end
			add_settle();
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (all_sent && expected_words.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
